// ===== rtl/stereo_slew_brightness_enhancer_assert.svh =====
// Assertion macros for the stereo slew brightness enhancer checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef STEREO_SLEW_BRIGHTNESS_ENHANCER_ASSERT_SVH
`define STEREO_SLEW_BRIGHTNESS_ENHANCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSBE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssbe: port sequence check failed");

// Next-cycle implication, disabled during reset.
`define SSBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssbe: port sequence check failed");

`endif

// ===== rtl/ssbe_pkg.sv =====
// Shared types and constants for the stereo slew brightness enhancer.
// No dependencies; used by the top level.
package ssbe_pkg;

	localparam int CFG_W     = 17;   // Q1.16 settings
	localparam int CFG_IDX_W = 2;
	localparam int GAIN_W    = 24;   // apply gain, signed Q2.21
	localparam int MUL_B_W   = 27;   // second operand of the shared multiplier
	localparam int CUBE_MSB  = 48;   // top bit of u^3 (u <= 2^16)

	localparam logic [CFG_W-1:0] ONE16     = 17'd65536;
	localparam logic [CFG_W-1:0] BOOST_RST = 17'd32768;
	localparam logic [CFG_W-1:0] LIMIT_RST = 17'd0;
	localparam logic [CFG_W-1:0] MIX_RST   = 17'd65536;

	// 1/1.3 in Q16
	localparam logic [15:0] INV13 = 16'd50412;

	// gain floor, -1.0 in Q21
	localparam logic signed [GAIN_W-1:0] GAIN_FLOOR = -24'sd2097152;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOOST = 2'd0,
		REG_LIMIT = 2'd1,
		REG_MIX   = 2'd2
	} ssbe_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CUBE1,
		ST_CUBE2,
		ST_INTEN,
		ST_ABS,
		ST_MAG,
		ST_SQ,
		ST_HARSH,
		ST_SENSE,
		ST_UPD,
		ST_WET,
		ST_MIX,
		ST_DONE
	} ssbe_state_t;

endpackage

// ===== rtl/stereo_slew_brightness_enhancer.sv =====
// Stereo slew brightness enhancer, top level.
// Depends on ssbe_pkg (types, constants).
//
// One transfer on the input channel carries a left/right sample pair; one transfer
// on the output channel returns the processed pair. All multiplications run through a
// single registered multiplier under a small sequencer: three products set up
// the slew threshold and the harshness weight from the settings, then seven
// products per channel build the harshness measure, the wet detail and the mix.
// The block takes no new pair until the sequencer has run through these products,
// the gain update step and the hand-off into the output register and is back in
// idle. in_stall stays high while a pair is in work. The output register lets a
// finished pair wait while the next pair is accepted; if the previous result is
// still stalled when the next one is done, the sequencer holds until the output
// register frees. Settings are written through the config port (cfg_ready is
// always high, unknown indexes ignored) and must only change while the block is
// idle.
module stereo_slew_brightness_enhancer #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [SAMPLE_BITS-1:0]       left_sample,
	input  logic signed [SAMPLE_BITS-1:0]       right_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_BITS-1:0]       left_out,
	output logic signed [SAMPLE_BITS-1:0]       right_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssbe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ssbe_pkg::CFG_W-1:0]          cfg_data
);

	localparam int W       = SAMPLE_BITS;
	localparam int W2      = SAMPLE_BITS + 2;
	localparam int W3      = SAMPLE_BITS + 3;
	localparam int FRAC    = SAMPLE_BITS - 1;
	// scaling of sample differences to Q23
	localparam int DN_SH   = (FRAC > 23) ? FRAC - 23 : 0;
	localparam int UP_SH   = (FRAC < 23) ? 23 - FRAC : 0;
	localparam int DIFF_W  = SAMPLE_BITS + 2 + UP_SH;
	localparam int MUL_A_W = (SAMPLE_BITS + 2 > 35) ? SAMPLE_BITS + 2 : 35;
	localparam int MUL_B_W = ssbe_pkg::MUL_B_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int GW      = ssbe_pkg::GAIN_W;

	localparam logic signed [W+2:0] OUT_HI = {4'b0000, {FRAC{1'b1}}};
	localparam logic signed [W+2:0] OUT_LO = {4'b1111, {FRAC{1'b0}}};

	// ---------------------------------------------------------------------------
	// Settings
	// ---------------------------------------------------------------------------
	logic [ssbe_pkg::CFG_W-1:0] boost_q, limit_q, mix_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boost_q <= ssbe_pkg::BOOST_RST;
			limit_q <= ssbe_pkg::LIMIT_RST;
			mix_q   <= ssbe_pkg::MIX_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ssbe_pkg::REG_BOOST: boost_q <= cfg_data;
				ssbe_pkg::REG_LIMIT: limit_q <= cfg_data;
				ssbe_pkg::REG_MIX:   mix_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Settings above 1.0 act as 1.0.
	logic [16:0]        b_sat, l_sat, w_sat, t_mag, u_val;
	logic signed [18:0] t_val, t3;

	always_comb begin
		b_sat = (boost_q > ssbe_pkg::ONE16) ? ssbe_pkg::ONE16 : boost_q;
		l_sat = (limit_q > ssbe_pkg::ONE16) ? ssbe_pkg::ONE16 : limit_q;
		w_sat = (mix_q   > ssbe_pkg::ONE16) ? ssbe_pkg::ONE16 : mix_q;
		// target = 2*boost - 1.0, slew base u = 1.0 - |target|
		t_val = $signed({1'b0, b_sat, 1'b0}) - $signed({2'b00, ssbe_pkg::ONE16});
		t_mag = t_val[18] ? 17'(-t_val) : t_val[16:0];
		u_val = ssbe_pkg::ONE16 - t_mag;
		// positive targets are tripled
		t3    = (t_val > 0) ? t_val + (t_val <<< 1) : t_val;
	end

	// ---------------------------------------------------------------------------
	// Sequencer and per-channel state
	// ---------------------------------------------------------------------------
	ssbe_pkg::ssbe_state_t state_q, state_d;
	logic                  ch_q;      // 0 = left, 1 = right

	logic signed [W-1:0]  x_q     [2];
	logic signed [W-1:0]  prev_q  [2];
	logic signed [W-1:0]  prev2_q [2];
	logic signed [GW-1:0] gain_q  [2];

	logic [W-1:0]         thr_q;      // slew threshold, Q.FRAC
	logic [18:0]          int_q;      // harshness weight 5*limit^2, Q16
	logic signed [W-1:0]  res_q;      // finished left sample
	logic signed [PROD_W-1:0] prod_q; // shared multiplier product

	logic                 out_valid_q;
	logic signed [W-1:0]  left_out_q, right_out_q;

	logic in_xfer, out_load;

	assign in_stall  = (state_q != ssbe_pkg::ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_load  = (state_q == ssbe_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssbe_pkg::ST_IDLE:  if (in_valid) state_d = ssbe_pkg::ST_CUBE1;
			ssbe_pkg::ST_CUBE1: state_d = ssbe_pkg::ST_CUBE2;
			ssbe_pkg::ST_CUBE2: state_d = ssbe_pkg::ST_INTEN;
			ssbe_pkg::ST_INTEN: state_d = ssbe_pkg::ST_ABS;
			ssbe_pkg::ST_ABS:   state_d = ssbe_pkg::ST_MAG;
			ssbe_pkg::ST_MAG:   state_d = ssbe_pkg::ST_SQ;
			ssbe_pkg::ST_SQ:    state_d = ssbe_pkg::ST_HARSH;
			ssbe_pkg::ST_HARSH: state_d = ssbe_pkg::ST_SENSE;
			ssbe_pkg::ST_SENSE: state_d = ssbe_pkg::ST_UPD;
			ssbe_pkg::ST_UPD:   state_d = ssbe_pkg::ST_WET;
			ssbe_pkg::ST_WET:   state_d = ssbe_pkg::ST_MIX;
			ssbe_pkg::ST_MIX:   state_d = ch_q ? ssbe_pkg::ST_DONE : ssbe_pkg::ST_ABS;
			ssbe_pkg::ST_DONE:  if (out_load) state_d = ssbe_pkg::ST_IDLE;
			default:            state_d = ssbe_pkg::ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------------
	// Channel datapath (selected by ch_q)
	// ---------------------------------------------------------------------------
	logic signed [W-1:0]      xc, pc, p2c;
	logic signed [GW-1:0]     gc;
	logic signed [W:0]        raw1, raw2, sum_xp;
	logic signed [DIFF_W-1:0] sc1, sc2;
	logic signed [24:0]       d1, d2;
	logic signed [25:0]       e_val, e_abs_w;
	logic [24:0]              abs_d1, abs_e;
	logic signed [W-1:0]      avg;
	logic signed [W+1:0]      dv, thr_s, diff;
	logic [29:0]              sense;
	logic signed [32:0]       gsum, gshr;
	logic signed [GW-1:0]     gnew;

	always_comb begin
		xc  = x_q[ch_q];
		pc  = prev_q[ch_q];
		p2c = prev2_q[ch_q];
		gc  = gain_q[ch_q];

		// first and second difference in Q23
		raw1   = (W+1)'(xc) - (W+1)'(pc);
		raw2   = (W+1)'(pc) - (W+1)'(p2c);
		sc1    = (DIFF_W'(raw1) >>> DN_SH) <<< UP_SH;
		sc2    = (DIFF_W'(raw2) >>> DN_SH) <<< UP_SH;
		d1     = sc1[24:0];
		d2     = sc2[24:0];
		e_val  = 26'(d1) - 26'(d2);
		abs_d1 = d1[24] ? 25'(-d1) : d1;
		e_abs_w = e_val[25] ? -e_val : e_val;
		abs_e  = e_abs_w[24:0];

		// clamp around the floor average of current and previous input;
		// diff is the part clamped away
		sum_xp = (W+1)'(xc) + (W+1)'(pc);
		avg    = sum_xp[W:1];
		dv     = W2'(xc) - W2'(avg);
		thr_s  = $signed({2'b00, thr_q});
		if (dv > thr_s) begin
			diff = dv - thr_s;
		end else if (-dv > thr_s) begin
			diff = dv + thr_s;
		end else begin
			diff = '0;
		end

		// gain update: floor((gain + 32*t - measure) / 2), floored at -1.0
		sense = prod_q[47:18];
		gsum  = 33'(gc) + (33'(t3) <<< 5) - $signed({3'b000, sense});
		gshr  = gsum >>> 1;
		gnew  = (gshr < 33'(ssbe_pkg::GAIN_FLOOR)) ? ssbe_pkg::GAIN_FLOOR : gshr[GW-1:0];
	end

	// x + mixed detail, saturated
	function automatic logic signed [W-1:0] sat_out(input logic signed [W-1:0] xv,
	                                                 input logic signed [W+1:0] qv);
		logic signed [W+2:0] s;
		s = W3'(xv) + W3'(qv);
		if (s > OUT_HI) begin
			sat_out = OUT_HI[W-1:0];
		end else if (s < OUT_LO) begin
			sat_out = OUT_LO[W-1:0];
		end else begin
			sat_out = s[W-1:0];
		end
	endfunction

	// ---------------------------------------------------------------------------
	// Shared multiplier operand select
	// ---------------------------------------------------------------------------
	logic                       mul_en;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ssbe_pkg::ST_CUBE1: begin    // u*u
				mul_a = MUL_A_W'(u_val);
				mul_b = MUL_B_W'(u_val);
			end
			ssbe_pkg::ST_CUBE2: begin    // u^2*u
				mul_a = MUL_A_W'(prod_q[33:0]);
				mul_b = MUL_B_W'(u_val);
			end
			ssbe_pkg::ST_INTEN: begin    // limit^2
				mul_a = MUL_A_W'(l_sat);
				mul_b = MUL_B_W'(l_sat);
			end
			ssbe_pkg::ST_ABS: begin      // |d1|*|e|
				mul_a = MUL_A_W'(abs_d1);
				mul_b = MUL_B_W'(abs_e);
			end
			ssbe_pkg::ST_MAG: begin      // a/1.3
				mul_a = MUL_A_W'(prod_q[48:23]);
				mul_b = MUL_B_W'(ssbe_pkg::INV13);
			end
			ssbe_pkg::ST_SQ: begin       // m*m
				mul_a = MUL_A_W'(prod_q[41:16]);
				mul_b = MUL_B_W'(prod_q[41:16]);
			end
			ssbe_pkg::ST_HARSH: begin    // (m^2 >> 23)/1.3
				mul_a = MUL_A_W'(prod_q[51:23]);
				mul_b = MUL_B_W'(ssbe_pkg::INV13);
			end
			ssbe_pkg::ST_SENSE: begin    // h*intensity
				mul_a = MUL_A_W'(prod_q[44:16]);
				mul_b = MUL_B_W'(int_q);
			end
			ssbe_pkg::ST_WET: begin      // clamped-away part * gain
				mul_a = MUL_A_W'(diff);
				mul_b = MUL_B_W'(gc);
			end
			ssbe_pkg::ST_MIX: begin      // detail * mix
				mul_a = MUL_A_W'($signed(prod_q[21 +: W2]));
				mul_b = MUL_B_W'(w_sat);
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// ---------------------------------------------------------------------------
	// Control and state registers
	// ---------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssbe_pkg::ST_IDLE;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				prev_q[i]  <= '0;
				prev2_q[i] <= '0;
				gain_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				ch_q <= 1'b0;
			end else if (state_q == ssbe_pkg::ST_MIX) begin
				ch_q <= 1'b1;
			end
			if (state_q == ssbe_pkg::ST_UPD) begin
				gain_q[ch_q] <= gnew;
			end
			// history shifts once this channel no longer needs it
			if (state_q == ssbe_pkg::ST_MIX) begin
				prev2_q[ch_q] <= prev_q[ch_q];
				prev_q[ch_q]  <= x_q[ch_q];
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q[0] <= left_sample;
			x_q[1] <= right_sample;
		end
		if (state_q == ssbe_pkg::ST_INTEN) begin
			thr_q <= prod_q[ssbe_pkg::CUBE_MSB -: W];
		end
		if (state_q == ssbe_pkg::ST_ABS) begin
			if (!ch_q) begin
				// (limit^2 >> 16) * 5
				int_q <= {prod_q[32:16], 2'b00} + 19'(prod_q[32:16]);
			end else begin
				// left mix product is still in the product register
				res_q <= sat_out(x_q[0], $signed(prod_q[16 +: W2]));
			end
		end
		if (out_load) begin
			left_out_q  <= res_q;
			right_out_q <= sat_out(x_q[1], $signed(prod_q[16 +: W2]));
		end
	end

endmodule

// ===== rtl/ssbe_checker.sv =====
// Port-level checker for the stereo slew brightness enhancer, bound to the top.
// Depends on stereo_slew_brightness_enhancer_assert.svh.
`include "stereo_slew_brightness_enhancer_assert.svh"

module ssbe_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [SAMPLE_BITS-1:0] left_out,
	input logic [SAMPLE_BITS-1:0] right_out
);

	// a transfer in makes the block busy
	`SSBE_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall)
	// no result shows up right after a transfer in
	`SSBE_ASSERT_NEXT(a_no_early_out, in_valid && !in_stall, !$rose(out_valid))
	// a result only follows a busy period
	`SSBE_ASSERT_SAME(a_out_after_busy, $rose(out_valid), $past(in_stall))
	// stalled result holds
	`SSBE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(left_out) && $stable(right_out))

endmodule

bind stereo_slew_brightness_enhancer ssbe_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_ssbe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.left_out  (left_out),
	.right_out (right_out)
);

// ===== dv/stereo_slew_brightness_enhancer_tb.sv =====
// Self-checking testbench for stereo_slew_brightness_enhancer: directed and random stereo pairs,
// settings phases and output back-pressure, checked against an in-bench fixed-point predictor.
// Depends on ssbe_pkg and the stereo_slew_brightness_enhancer RTL.
module stereo_slew_brightness_enhancer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC        = SAMPLE_BITS - 1;

	// Predictor constants, all in 64-bit signed so mixed-width math stays signed
	localparam longint Q16_UNITY = 65536;
	localparam longint RECIP_1P3 = 50412;          // 1/1.3 in Q16
	localparam longint GAIN_LOW  = -(64'sd1 <<< 21); // -1.0 in Q2.21
	localparam longint SAT_HI    = (64'sd1 <<< FRAC) - 1;
	localparam longint SAT_LO    = -(64'sd1 <<< FRAC);

	localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Index with no register behind it; writes must be dropped
	localparam logic [ssbe_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int SETTLE_CYCLES = 24;    // margin for the sequencer to go idle after draining
	localparam int QUIET_LIMIT   = 2000;  // cycles without any transfer before giving up
	localparam int PHASE_PAIRS   = 125;
	localparam int PHASES        = 6;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left;
		logic signed [SAMPLE_BITS-1:0] right;
	} stereo_pair_t;

	// DUT ports, every input known from time zero
	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           in_valid     = 1'b0;
	logic                           in_stall;
	logic signed [SAMPLE_BITS-1:0]  left_sample  = '0;
	logic signed [SAMPLE_BITS-1:0]  right_sample = '0;
	logic                           out_valid;
	logic                           out_stall    = 1'b0;
	logic signed [SAMPLE_BITS-1:0]  left_out;
	logic signed [SAMPLE_BITS-1:0]  right_out;
	logic                           cfg_valid    = 1'b0;
	logic                           cfg_ready;
	logic [ssbe_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [ssbe_pkg::CFG_W-1:0]     cfg_data     = '0;

	// Predictor copy of settings and per-channel history (index 0 = left, 1 = right)
	logic [ssbe_pkg::CFG_W-1:0] boost_q16   = ssbe_pkg::BOOST_RST;
	logic [ssbe_pkg::CFG_W-1:0] limit_q16   = ssbe_pkg::LIMIT_RST;
	logic [ssbe_pkg::CFG_W-1:0] mix_q16     = ssbe_pkg::MIX_RST;
	longint                     prev_x[2]   = '{0, 0};
	longint                     prev2_x[2]  = '{0, 0};
	longint                     gain_q21[2] = '{0, 0};

	stereo_pair_t pending_pairs[$];

	// Stimulus bookkeeping
	longint last_left  = 0;
	longint last_right = 0;
	bit     play_idle  = 1'b1;
	bit     sink_idle  = 1'b1;
	int     sink_hold  = 0;

	int pairs_played = 0;
	int pairs_heard  = 0;
	int reg_writes   = 0;
	int error_count  = 0;
	int quiet_cycles = 0;

	stereo_slew_brightness_enhancer #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.left_sample (left_sample),
		.right_sample(right_sample),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.left_out    (left_out),
		.right_out   (right_out),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void flag_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endfunction

	// One channel of the enhancer: harshness measure, gain smoothing, slew clamp,
	// detail re-injection, dry/wet blend and saturation. Updates channel history.
	function automatic logic signed [SAMPLE_BITS-1:0] enhance_channel(input int ch,
			input longint x, input longint tgt, input longint thr, input longint inten,
			input longint wetq);
		longint d1, d2, dd, ad, ae, mag, m, h, sense, g, avg, clamped, wet, res;
		d1  = x - prev_x[ch];
		d2  = prev_x[ch] - prev2_x[ch];
		dd  = d1 - d2;
		ad  = (d1 < 0) ? -d1 : d1;
		ae  = (dd < 0) ? -dd : dd;
		mag = (ad * ae) >>> 23;
		m   = (mag * RECIP_1P3) >>> 16;
		h   = (((m * m) >>> 23) * RECIP_1P3) >>> 16;
		sense = (h * inten) >>> 18;
		// gain moves halfway toward target minus harshness, never below -1.0
		g = (gain_q21[ch] + tgt * 32 - sense) >>> 1;
		if (g < GAIN_LOW)
			g = GAIN_LOW;
		gain_q21[ch] = g;
		avg     = (x + prev_x[ch]) >>> 1;
		clamped = x;
		if (x - avg > thr)
			clamped = avg + thr;
		if (avg - x > thr)
			clamped = avg - thr;
		wet = x + (((x - clamped) * g) >>> 21);
		res = (wet * wetq + x * (Q16_UNITY - wetq)) >>> 16;
		if (res > SAT_HI)
			res = SAT_HI;
		if (res < SAT_LO)
			res = SAT_LO;
		prev2_x[ch] = prev_x[ch];
		prev_x[ch]  = x;
		return res[SAMPLE_BITS-1:0];
	endfunction

	// Settings-derived terms shared by both channels, then each channel in turn
	function automatic stereo_pair_t predict_pair(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r);
		longint b, lim, w, tgt, u, thr, inten;
		stereo_pair_t res;
		// settings above 1.0 act as 1.0
		b   = (boost_q16 > Q16_UNITY) ? Q16_UNITY : boost_q16;
		lim = (limit_q16 > Q16_UNITY) ? Q16_UNITY : limit_q16;
		w   = (mix_q16 > Q16_UNITY) ? Q16_UNITY : mix_q16;
		tgt = 2 * b - Q16_UNITY;
		u   = Q16_UNITY - ((tgt < 0) ? -tgt : tgt);
		thr = (u * u * u) >>> (48 - FRAC);
		inten = ((lim * lim) >>> 16) * 5;
		if (tgt > 0)
			tgt = tgt * 3;
		res.left  = enhance_channel(0, l, tgt, thr, inten, w);
		res.right = enhance_channel(1, r, tgt, thr, inten, w);
		return res;
	endfunction

	// Mostly small moves around the last value (audio-like), plus full-range noise,
	// rail values and large opposite-rail jumps
	function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input longint last);
		int     kind;
		int     span;
		longint v;
		kind = $urandom_range(0, 99);
		if (kind < 50) begin
			span = $urandom_range(2, 21);
			v = last + longint'($urandom_range(0, (1 << span) - 1)) - (64'sd1 <<< (span - 1));
			if (v > SAT_HI)
				v = SAT_HI;
			if (v < SAT_LO)
				v = SAT_LO;
		end else if (kind < 70) begin
			v = longint'($urandom());
		end else if (kind < 85) begin
			case ($urandom_range(0, 3))
				0: v = SAT_HI;
				1: v = SAT_LO;
				2: v = 0;
				default: v = -1;
			endcase
		end else begin
			v = (last >= 0) ? SAT_LO + $urandom_range(0, 4095) : SAT_HI - $urandom_range(0, 4095);
		end
		return v[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [ssbe_pkg::CFG_W-1:0] draw_setting();
		logic [ssbe_pkg::CFG_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = ssbe_pkg::ONE16;
			2: v = ssbe_pkg::CFG_W'($urandom_range(65537, 131071));  // above range, acts as 1.0
			default: v = ssbe_pkg::CFG_W'($urandom_range(0, 65536));
		endcase
		return v;
	endfunction

	// Config write; updates the predictor's settings on the transfer
	task automatic write_setting(input logic [ssbe_pkg::CFG_IDX_W-1:0] idx,
			input logic [ssbe_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			ssbe_pkg::REG_BOOST: boost_q16 = val;
			ssbe_pkg::REG_LIMIT: limit_q16 = val;
			ssbe_pkg::REG_MIX:   mix_q16   = val;
			default: ;  // unknown index, dropped by the block
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offer one pair. Called at a falling edge; returns at the falling edge after
	// the transfer with in_valid still high, so back-to-back pairs need no gap.
	task automatic play_pair(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r);
		int gap;
		gap = play_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		left_sample  <= l;
		right_sample <= r;
		last_left  = l;
		last_right = r;
		do @(posedge clk); while (in_stall);
		pending_pairs.push_back(predict_pair(l, r));
		pairs_played++;
		@(negedge clk);
	endtask

	// Drop valid, drain every expected result, then let the sequencer go idle
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Reset settings: zero target gain, zero harshness weight, fully wet.
	// Rail-to-rail steps exercise the harshness path at its largest.
	task automatic test_reset_defaults();
		play_pair('0, '0);
		play_pair(FULL_POS, FULL_NEG);
		play_pair(FULL_NEG, FULL_POS);
		play_pair(SAMPLE_BITS'(-1), SAMPLE_BITS'(1));
		settle_block();
	endtask

	// Corner settings, including values above range and a write to an unused index
	task automatic test_setting_extremes();
		logic [ssbe_pkg::CFG_W-1:0] corner[4][3];
		corner = '{
			'{17'd0,      17'd65536,  17'd0},
			'{17'd65536,  17'd0,      17'd65536},
			'{17'd131071, 17'd131071, 17'd131071},
			'{17'd49152,  17'd32768,  17'd32768}
		};
		for (int i = 0; i < 4; i++) begin
			write_setting(ssbe_pkg::REG_BOOST, corner[i][0]);
			write_setting(ssbe_pkg::REG_LIMIT, corner[i][1]);
			write_setting(ssbe_pkg::REG_MIX,   corner[i][2]);
			if (i == 3)
				write_setting(REG_UNUSED, 17'h1ffff);
			play_pair(FULL_POS, FULL_NEG);
			play_pair(FULL_NEG, FULL_POS);
			play_pair(draw_sample(last_left), draw_sample(last_right));
			settle_block();
		end
	endtask

	// Full boost, no harshness pull: gain climbs toward 3.0 and drives the output into saturation
	task automatic test_output_saturation();
		write_setting(ssbe_pkg::REG_BOOST, ssbe_pkg::ONE16);
		write_setting(ssbe_pkg::REG_LIMIT, '0);
		write_setting(ssbe_pkg::REG_MIX,   ssbe_pkg::ONE16);
		for (int i = 0; i < 5; i++)
			play_pair(i[0] ? FULL_POS : FULL_NEG, i[0] ? FULL_NEG : FULL_POS);
		settle_block();
	endtask

	// Receiver holds off for a long stretch while pairs keep coming back to back:
	// the output register fills, the sequencer blocks and in_stall must hold the input.
	task automatic test_backpressure();
		play_idle = 1'b0;
		sink_hold = 300;
		for (int i = 0; i < 10; i++)
			play_pair(draw_sample(last_left), draw_sample(last_right));
		play_idle = 1'b1;
		settle_block();
	endtask

	// Settings phases with random pairs; one phase runs both sides with no idling
	task automatic test_random_phases();
		for (int p = 0; p < PHASES; p++) begin
			write_setting(ssbe_pkg::REG_BOOST, draw_setting());
			write_setting(ssbe_pkg::REG_LIMIT, draw_setting());
			write_setting(ssbe_pkg::REG_MIX,   draw_setting());
			if ($urandom_range(0, 1))
				write_setting(REG_UNUSED, draw_setting());
			play_idle = (p == 1) ? 1'b0 : (p == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			sink_idle = (p == 1) ? 1'b0 : (p == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			for (int i = 0; i < PHASE_PAIRS; i++)
				play_pair(draw_sample(last_left), draw_sample(last_right));
			settle_block();
		end
		play_idle = 1'b1;
		sink_idle = 1'b1;
	endtask

	// Receiver: random stall before each result, plus any long hold-off requested
	initial begin : result_sink
		int pause;
		wait (arst_n);
		forever begin
			pause = sink_idle ? $urandom_range(0, 19) : 0;
			pause += sink_hold;
			sink_hold = 0;
			if (pause > 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Each output transfer is checked against the oldest expected pair
	always @(posedge clk) begin : result_check
		stereo_pair_t want;
		if (arst_n && out_valid && !out_stall) begin
			pairs_heard++;
			if (pending_pairs.size() == 0) begin
				flag_error($sformatf("unexpected result L=%0d R=%0d", left_out, right_out));
			end else begin
				want = pending_pairs.pop_front();
				if (left_out !== want.left)
					flag_error($sformatf("left  expected %0d got %0d", want.left, left_out));
				if (right_out !== want.right)
					flag_error($sformatf("right expected %0d got %0d", want.right, right_out));
			end
		end
	end

	// Watchdog: ends the run if no transfer happens on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[%0t] TIMEOUT: no transfer for %0d cycles, %0d results outstanding",
					$realtime, QUIET_LIMIT, pending_pairs.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_setting_extremes();
		test_output_saturation();
		test_backpressure();
		test_random_phases();

		settle_block();
		while (pending_pairs.size() != 0) begin
			stereo_pair_t left_over;
			left_over = pending_pairs.pop_front();
			flag_error($sformatf("no result for expected L=%0d R=%0d", left_over.left,
				left_over.right));
		end

		$display("Run covered %0d stereo pairs in and %0d out, %0d register writes, %0d phases.",
			pairs_played, pairs_heard, reg_writes, PHASES);
		$display("Mismatches: %0d (rails, setting corners, saturation, long output hold-off).",
			error_count);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
